/* design/gcns_pkg.sv */
package gcns_pkg;

    // Default sizes handed to the top level
    localparam int DEF_MAX_PARTICLES  = 1024;
    localparam int DEF_GRID_WIDTH     = 64;
    localparam int DEF_GRID_HEIGHT    = 64;
    localparam int DEF_CELL_SHIFT     = 9;
    localparam int DEF_MAX_NEIGHBOURS = 32;

    // Hard cap on results per query (slot_number is 5 bits)
    localparam int RESULT_CAP = 32;

    // Configuration register indexes
    localparam logic CFG_MAX_DIST_SQ = 1'b0;
    localparam logic CFG_MIN_DIST_SQ = 1'b1;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic               start_req;
        logic [9:0]         particle_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } req_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [9:0]  neighbour_index;
        logic [15:0] distance;
        logic [4:0]  slot_number;
        logic        last;
    } rsp_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cap_in;
        logic clr_start;
        logic clr_step;
        logic load_rd;
        logic load_wr;
        logic q_rd;
        logic q_lat;
        logic cell_rd;
        logic cell_lat;
        logic cell_adv;
        logic walk_rd;
        logic walk_lat;
        logic mul;
        logic sum;
        logic sqrt_init;
        logic sqrt_step;
        logic push;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_query;
        logic start_req;
        logic p_oob;
        logic clr_done;
        logic walk_end;
        logic cap_hit;
        logic cell_last;
        logic in_range;
        logic sqrt_done;
        logic held_valid;
        logic out_free;
    } stat_t;

endpackage

/* design/gcns_ram.sv */
module gcns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/gcns_ctrl.sv */
module gcns_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  gcns_pkg::stat_t       stat,
    output gcns_pkg::cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_LOAD_RD, S_LOAD_WR, S_Q_RD, S_Q_LAT, S_CELL_RD,
        S_CELL_LAT, S_WALK_CHK, S_WALK_RD, S_WALK_LAT, S_MUL, S_SUM, S_CHK,
        S_SQRT, S_PUSH, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    assign req_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_LOAD_RD : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            // Captured item is visible from here on
            S_DECODE:
            begin
                if (stat.op_query)
                begin
                    state_next = S_Q_RD;
                end
                else if (stat.start_req)
                begin
                    cmd.clr_start = 1'b1;
                    pend_next     = 1'b1;
                    state_next    = S_CLEAR;
                end
                else
                begin
                    state_next = S_LOAD_RD;
                end
            end
            S_LOAD_RD:
            begin
                if (stat.p_oob)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.load_rd = 1'b1;
                    state_next  = S_LOAD_WR;
                end
            end
            S_LOAD_WR:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_Q_RD:
            begin
                if (stat.p_oob)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_Q_LAT;
                end
            end
            S_Q_LAT:
            begin
                cmd.q_lat  = 1'b1;
                state_next = S_CELL_RD;
            end
            S_CELL_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = S_CELL_LAT;
            end
            S_CELL_LAT:
            begin
                cmd.cell_lat = 1'b1;
                state_next   = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (stat.cap_hit)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.walk_end)
                begin
                    if (stat.cell_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.cell_adv = 1'b1;
                        state_next   = S_CELL_RD;
                    end
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_LAT;
            end
            S_WALK_LAT:
            begin
                cmd.walk_lat = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.in_range)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = S_SQRT;
                end
                else
                begin
                    state_next = S_WALK_CHK;
                end
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            S_PUSH:
            begin
                if (!stat.held_valid || stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

/* design/gcns_dp.sv */
module gcns_dp #(
    parameter int MAX_PARTICLES  = gcns_pkg::DEF_MAX_PARTICLES,
    parameter int GRID_WIDTH     = gcns_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT    = gcns_pkg::DEF_GRID_HEIGHT,
    parameter int CELL_SHIFT     = gcns_pkg::DEF_CELL_SHIFT,
    parameter int MAX_NEIGHBOURS = gcns_pkg::DEF_MAX_NEIGHBOURS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  gcns_pkg::req_item_t req_item,
    input  gcns_pkg::cmd_t      cmd,
    output gcns_pkg::stat_t     stat,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gcns_pkg::rsp_item_t rsp_item
);

    localparam int AW    = $clog2(MAX_PARTICLES);
    localparam int LW    = $clog2(MAX_PARTICLES + 1);
    localparam int CXW   = $clog2(GRID_WIDTH);
    localparam int CYW   = $clog2(GRID_HEIGHT);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int CAW   = $clog2(CELLS);
    localparam int PWW   = LW + CYW + CXW + 32;
    localparam int LIMIT = (MAX_NEIGHBOURS < gcns_pkg::RESULT_CAP) ?
                           MAX_NEIGHBOURS : gcns_pkg::RESULT_CAP;

    // Bin one coordinate, clamped to the grid interior
    function automatic logic [31:0] bin_coord(input logic signed [15:0] pos,
                                              input logic [31:0] size);
        logic [31:0] c;
        c = pos[15] ? 32'd0 : (32'(pos[14:0]) >> CELL_SHIFT);
        if (c < 32'd1)
        begin
            c = 32'd1;
        end
        if (c > size - 32'd2)
        begin
            c = size - 32'd2;
        end
        return c;
    endfunction

    logic [31:0]         max_reg, min_reg;
    gcns_pkg::req_item_t item_reg;
    logic [CAW-1:0]      clr_reg;
    logic [CXW-1:0]      gx_reg;
    logic [CYW-1:0]      gy_reg;
    logic [1:0]          ox_reg, oy_reg;
    logic signed [15:0]  xi_reg, yi_reg;
    logic [LW-1:0]       link_reg;
    logic [LW-1:0]       steps_reg;
    logic [LW-1:0]       j_reg;
    logic [15:0]         dx_reg, dy_reg;
    logic [31:0]         sqx_reg, sqy_reg;
    logic [32:0]         d2_reg;
    logic [33:0]         sv_reg, sres_reg, sbit_reg;
    logic [5:0]          count_reg;
    logic                held_reg;
    gcns_pkg::rsp_item_t held_item_reg;
    logic                rsp_valid_reg;
    gcns_pkg::rsp_item_t rsp_item_reg;

    logic [31:0]     cx_in, cy_in, cell_in32, ncell32, j32;
    logic [LW-1:0]   link_m1;
    logic [AW-1:0]   p_addr;
    logic [LW-1:0]   p_link;
    logic [CAW-1:0]  cell_addr;
    logic            cell_we;
    logic [LW-1:0]   cell_wdata, cell_rdata;
    logic [AW-1:0]   part_addr;
    logic [PWW-1:0]  part_wdata, part_rdata;
    logic signed [16:0] ddx, ddy;
    logic [33:0]     ssum;
    logic            out_free;
    gcns_pkg::rsp_item_t fin_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 32'd65536;
            min_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gcns_pkg::CFG_MAX_DIST_SQ: max_reg <= cfg_data;
                gcns_pkg::CFG_MIN_DIST_SQ: min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Addresses and cell numbers
    assign cx_in     = bin_coord(item_reg.pos_x, 32'(GRID_WIDTH));
    assign cy_in     = bin_coord(item_reg.pos_y, 32'(GRID_HEIGHT));
    assign cell_in32 = cx_in + cy_in * 32'(GRID_WIDTH);
    assign ncell32   = (32'(gx_reg) + 32'(ox_reg) - 32'd1)
                     + (32'(gy_reg) + 32'(oy_reg) - 32'd1) * 32'(GRID_WIDTH);
    assign link_m1   = link_reg - LW'(1);
    assign j32       = 32'(j_reg);
    assign p_addr    = AW'(item_reg.particle_index);
    assign p_link    = LW'(item_reg.particle_index) + LW'(1);

    // Cell head memory port
    always_comb
    begin
        cell_we    = cmd.clr_step | cmd.load_wr;
        cell_wdata = cmd.clr_step ? '0 : p_link;
        if (cmd.clr_step)
        begin
            cell_addr = clr_reg;
        end
        else if (cmd.load_rd || cmd.load_wr)
        begin
            cell_addr = cell_in32[CAW-1:0];
        end
        else
        begin
            cell_addr = ncell32[CAW-1:0];
        end
    end

    gcns_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .addr  (cell_addr),
        .wdata (cell_wdata),
        .rdata (cell_rdata)
    );

    // Particle memory port: {link, cy, cx, y, x}
    assign part_addr  = (cmd.load_wr || cmd.q_rd) ? p_addr : link_m1[AW-1:0];
    assign part_wdata = {cell_rdata, CYW'(cy_in), CXW'(cx_in),
                         item_reg.pos_y, item_reg.pos_x};

    gcns_ram #(.WIDTH(PWW), .DEPTH(MAX_PARTICLES)) u_part_ram (
        .clk   (clk),
        .we    (cmd.load_wr),
        .addr  (part_addr),
        .wdata (part_wdata),
        .rdata (part_rdata)
    );

    // Distance terms
    assign ddx  = 17'(signed'(part_rdata[15:0])) - 17'(xi_reg);
    assign ddy  = 17'(signed'(part_rdata[31:16])) - 17'(yi_reg);
    assign ssum = sres_reg + sbit_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            item_reg <= req_item;
        end
        if (cmd.q_lat)
        begin
            xi_reg <= signed'(part_rdata[15:0]);
            yi_reg <= signed'(part_rdata[31:16]);
            gx_reg <= part_rdata[32 +: CXW];
            gy_reg <= part_rdata[32 + CXW +: CYW];
        end
        if (cmd.walk_lat)
        begin
            j_reg  <= link_m1;
            dx_reg <= ddx[16] ? 16'(-ddx) : ddx[15:0];
            dy_reg <= ddy[16] ? 16'(-ddy) : ddy[15:0];
        end
        if (cmd.mul)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
        end
        if (cmd.sum)
        begin
            d2_reg <= 33'(sqx_reg) + 33'(sqy_reg);
        end
        // One root bit per cycle
        if (cmd.sqrt_init)
        begin
            sv_reg   <= 34'(d2_reg);
            sres_reg <= '0;
            sbit_reg <= 34'd1 << 32;
        end
        else if (cmd.sqrt_step)
        begin
            if (sv_reg >= ssum)
            begin
                sv_reg   <= sv_reg - ssum;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
        if (cmd.push)
        begin
            held_item_reg.valid_res       <= 1'b1;
            held_item_reg.neighbour_index <= j32[9:0];
            held_item_reg.distance        <= sres_reg[15:0];
            held_item_reg.slot_number     <= count_reg[4:0];
            held_item_reg.last            <= 1'b0;
        end
    end

    // Walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            link_reg  <= '0;
            steps_reg <= '0;
            count_reg <= '0;
            held_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CAW'(1);
            end
            if (cmd.cap_in || cmd.finish)
            begin
                count_reg <= '0;
                held_reg  <= 1'b0;
            end
            else if (cmd.push)
            begin
                count_reg <= count_reg + 6'd1;
                held_reg  <= 1'b1;
            end
            if (cmd.q_lat)
            begin
                ox_reg <= '0;
                oy_reg <= '0;
            end
            else if (cmd.cell_adv)
            begin
                if (oy_reg == 2'd2)
                begin
                    oy_reg <= '0;
                    ox_reg <= ox_reg + 2'd1;
                end
                else
                begin
                    oy_reg <= oy_reg + 2'd1;
                end
            end
            if (cmd.cell_lat)
            begin
                link_reg  <= cell_rdata;
                steps_reg <= '0;
            end
            else if (cmd.walk_lat)
            begin
                link_reg  <= part_rdata[PWW-1 -: LW];
                steps_reg <= steps_reg + LW'(1);
            end
        end
    end

    // Output register
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish || (cmd.push && held_reg))
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Final result of a query: held neighbour, or the empty marker
    always_comb
    begin
        fin_item      = held_reg ? held_item_reg : '0;
        fin_item.last = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_item_reg <= fin_item;
        end
        else if (cmd.push && held_reg)
        begin
            rsp_item_reg <= held_item_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Status
    always_comb
    begin
        stat            = '0;
        stat.op_query   = (item_reg.op == gcns_pkg::OP_QUERY);
        stat.start_req  = item_reg.start_req;
        stat.p_oob      = 32'(item_reg.particle_index) >= 32'(MAX_PARTICLES);
        stat.clr_done   = (clr_reg == CAW'(CELLS - 1));
        stat.walk_end   = (link_reg == '0) || (steps_reg == LW'(MAX_PARTICLES));
        stat.cap_hit    = (count_reg == 6'(LIMIT));
        stat.cell_last  = (ox_reg == 2'd2) && (oy_reg == 2'd2);
        stat.in_range   = (d2_reg >= 33'(min_reg)) && (d2_reg <= 33'(max_reg));
        stat.sqrt_done  = (sbit_reg == '0);
        stat.held_valid = held_reg;
        stat.out_free   = out_free;
    end

endmodule

/* design/grid_cell_neighbour_search.sv */
// Channel  Signals                              Dir  Transfer
// req      req_valid, req_stall, req_item       in   req_valid && !req_stall
// rsp      rsp_valid, rsp_stall, rsp_item       out  rsp_valid && !rsp_stall
// cfg      cfg_we, cfg_index, cfg_data          in   cfg_we
//
// Load: with start_req the GRID_WIDTH*GRID_HEIGHT cell heads are cleared first.
// Query: per cell the head is read and each link walked; each neighbour found takes a 17-step root.
// After reset all GRID_WIDTH*GRID_HEIGHT cell heads are swept, req stalled.
// One item at a time; req_stall is high while an item is in work.
// rsp_stall holds the output register; the walk waits when a second result is ready, the last result also.
module grid_cell_neighbour_search #(
    parameter int MAX_PARTICLES  = gcns_pkg::DEF_MAX_PARTICLES,
    parameter int GRID_WIDTH     = gcns_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT    = gcns_pkg::DEF_GRID_HEIGHT,
    parameter int CELL_SHIFT     = gcns_pkg::DEF_CELL_SHIFT,
    parameter int MAX_NEIGHBOURS = gcns_pkg::DEF_MAX_NEIGHBOURS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  gcns_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gcns_pkg::rsp_item_t rsp_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    gcns_pkg::cmd_t  cmd;
    gcns_pkg::stat_t stat;

    gcns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    gcns_dp #(
        .MAX_PARTICLES  (MAX_PARTICLES),
        .GRID_WIDTH     (GRID_WIDTH),
        .GRID_HEIGHT    (GRID_HEIGHT),
        .CELL_SHIFT     (CELL_SHIFT),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule
